### design/csfr_pkg.sv
package csfr_pkg;

  // Field widths
  localparam int unsigned RT_W    = 10;
  localparam int unsigned CAL_W   = 20;
  localparam int unsigned FREQ_W  = 20;
  localparam int unsigned COLOR_W = 8;
  localparam int unsigned COUNT_W = 32;
  localparam int unsigned CH_W    = 2;
  localparam int unsigned IDX_W   = 3;
  localparam int unsigned CFG_W   = 20;
  localparam int unsigned CHANNELS = 3;

  // Divider operand widths: count times 1000 needs 42 bits.
  localparam int unsigned DVD_W = 42;
  localparam int unsigned DSR_W = 20;

  localparam logic [COUNT_W-1:0] COUNT_MAX  = 32'd4000000000;
  localparam logic [FREQ_W-1:0]  FREQ_MAX   = 20'hFFFFF;
  localparam logic [9:0]         MS_PER_S   = 10'd1000;
  localparam logic [COLOR_W-1:0] COLOR_MAX  = 8'd255;

  // Register reset values
  localparam logic [RT_W-1:0]  RT_RESET    = 10'd100;
  localparam logic [CAL_W-1:0] DARK_RESET  = 20'd6000;
  localparam logic [CAL_W-1:0] WHITE_RESET = 20'd55000;
  localparam logic [1:0]       SCALE_RESET = 2'd3;

  // Input operations
  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_START  = 1'b1;

  // Configuration register indexes
  typedef enum logic [IDX_W-1:0] {
    REG_READ_TIME   = 3'd0,
    REG_DARK_RED    = 3'd1,
    REG_DARK_GREEN  = 3'd2,
    REG_DARK_BLUE   = 3'd3,
    REG_WHITE_RED   = 3'd4,
    REG_WHITE_GREEN = 3'd5,
    REG_WHITE_BLUE  = 3'd6,
    REG_SCALE       = 3'd7
  } reg_idx_e;

  // Filter windows
  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_RED   = 2'd1,
    PH_GREEN = 2'd2,
    PH_BLUE  = 2'd3
  } phase_e;

  // S2S3 filter select codes
  localparam logic [1:0] FILTER_RED   = 2'b00;
  localparam logic [1:0] FILTER_GREEN = 2'b11;
  localparam logic [1:0] FILTER_BLUE  = 2'b01;
  localparam logic [1:0] FILTER_OFF   = 2'b00;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic take;       // item accepted this cycle
    logic mul_start;  // scale count by 1000 and start the frequency divide
    logic cal_load;   // capture frequency and calibration differences
    logic cal_start;  // start the calibration divide
    logic finish;     // write the window result to the output register
  } csfr_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic close;     // the offered item closes a window
    logic out_free;  // output register can take an item this cycle
    logic div_busy;  // serial divider is running
  } csfr_sts_t;

  // One result item
  typedef struct packed {
    logic [1:0]         filter_pins;
    logic               sensor_enable;
    logic [1:0]         scale_pins;
    logic               busy_res;
    logic               result_valid;
    logic [CH_W-1:0]    channel;
    logic [FREQ_W-1:0]  raw_frequency;
    logic [COLOR_W-1:0] color_value;
    logic               last;
  } result_t;

  // Filter pins for a window.
  function automatic logic [1:0] filter_code(input phase_e ph);
    logic [1:0] code;
    unique case (ph)
      PH_RED:   code = FILTER_RED;
      PH_GREEN: code = FILTER_GREEN;
      PH_BLUE:  code = FILTER_BLUE;
      default:  code = FILTER_OFF;
    endcase
    return code;
  endfunction

endpackage

### design/csfr_in_if.sv
interface csfr_in_if;
  logic valid;
  logic ready;
  logic op;
  logic pin_level;
  logic ms_tick;

  modport source (output valid, output op, output pin_level, output ms_tick, input ready);
  modport sink (input valid, input op, input pin_level, input ms_tick, output ready);
endinterface

### design/csfr_out_if.sv
interface csfr_out_if import csfr_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [1:0]         filter_pins;
  logic               sensor_enable;
  logic [1:0]         scale_pins;
  logic               busy_res;
  logic               result_valid;
  logic [CH_W-1:0]    channel;
  logic [FREQ_W-1:0]  raw_frequency;
  logic [COLOR_W-1:0] color_value;
  logic               last;

  modport source (
    output valid, output filter_pins, output sensor_enable, output scale_pins,
    output busy_res, output result_valid, output channel, output raw_frequency,
    output color_value, output last, input ready
  );
  modport sink (
    input valid, input filter_pins, input sensor_enable, input scale_pins,
    input busy_res, input result_valid, input channel, input raw_frequency,
    input color_value, input last, output ready
  );
endinterface

### design/csfr_cfg_if.sv
interface csfr_cfg_if import csfr_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] index;
  logic [CFG_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

### design/csfr_div.sv
module csfr_div import csfr_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DVD_W-1:0] dividend_i,
  input  logic [DSR_W-1:0] divisor_i,
  output logic             busy_o,
  output logic [DVD_W-1:0] quotient_o
);

  localparam int unsigned CNT_W = $clog2(DVD_W + 1);

  logic             busy_q;
  logic [CNT_W-1:0] cnt_q;
  logic [DSR_W-1:0] rem_q;
  logic [DSR_W-1:0] dsr_q;
  logic [DVD_W-1:0] dvd_q;

  logic [DSR_W:0]   trial;
  logic [DSR_W:0]   diff;
  logic             fits;

  // One restoring step: bring down the next dividend bit and try a subtract.
  always_comb begin
    trial = {rem_q, dvd_q[DVD_W-1]};
    diff  = trial - {1'b0, dsr_q};
    fits  = trial >= {1'b0, dsr_q};
  end

  // Control: busy flag and step counter.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CNT_W'(DVD_W);
    end else if (busy_q) begin
      cnt_q <= cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  // Remainder and dividend shift register; quotient bits enter at the bottom.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      dsr_q <= divisor_i;
      dvd_q <= dividend_i;
    end else if (busy_q) begin
      rem_q <= fits ? diff[DSR_W-1:0] : trial[DSR_W-1:0];
      dvd_q <= {dvd_q[DVD_W-2:0], fits};
    end
  end

  assign busy_o     = busy_q;
  assign quotient_o = dvd_q;

endmodule

### design/csfr_datapath.sv
module csfr_datapath import csfr_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  csfr_cmd_t        cmd_i,
  output csfr_sts_t        sts_o,
  input  logic             op_i,
  input  logic             pin_level_i,
  input  logic             ms_tick_i,
  input  logic             cfg_we_i,
  input  logic [IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0] cfg_data_i,
  input  logic             out_ready_i,
  output logic             out_valid_o,
  output result_t          out_item_o
);

  // Configuration registers
  logic [RT_W-1:0]  read_time_q;
  logic [CAL_W-1:0] dark_q  [CHANNELS];
  logic [CAL_W-1:0] white_q [CHANNELS];
  logic [1:0]       scale_q;

  // Measurement state
  phase_e           phase_q, phase_d;
  logic [COUNT_W-1:0] count_q, count_d, count_inc;
  logic [RT_W-1:0]  elapsed_q, elapsed_d, elapsed_inc;
  logic             prev_q, prev_d;
  logic             close;
  logic             edge_inc;
  logic [RT_W-1:0]  rt_eff;

  // Window result path
  logic [COUNT_W-1:0]  snap_q;
  logic [CH_W-1:0]     ch_q;
  logic                last_q;
  logic [FREQ_W-1:0]   freq_q;
  logic [FREQ_W:0]     diff_q;
  logic [FREQ_W:0]     den_q;
  logic                pos_q;
  logic [FREQ_W-1:0]   freq_sat;
  logic [FREQ_W:0]     abs_diff;
  logic [FREQ_W:0]     abs_den;
  logic [FREQ_W+8:0]   abs_num;
  logic [COLOR_W-1:0]  color;
  logic [DVD_W-1:0]    prod;

  // Divider hookup
  logic             div_start;
  logic [DVD_W-1:0] div_dividend;
  logic [DSR_W-1:0] div_divisor;
  logic             div_busy;
  logic [DVD_W-1:0] div_quot;

  // Output register
  logic    out_valid_q;
  result_t out_q;
  logic    out_free;

  assign rt_eff = (read_time_q == '0) ? RT_W'(1) : read_time_q;

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      read_time_q <= RT_RESET;
      for (int i = 0; i < CHANNELS; i++) begin
        dark_q[i]  <= DARK_RESET;
        white_q[i] <= WHITE_RESET;
      end
      scale_q <= SCALE_RESET;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_index_i))
        REG_READ_TIME:   read_time_q <= cfg_data_i[RT_W-1:0];
        REG_DARK_RED:    dark_q[0]   <= cfg_data_i[CAL_W-1:0];
        REG_DARK_GREEN:  dark_q[1]   <= cfg_data_i[CAL_W-1:0];
        REG_DARK_BLUE:   dark_q[2]   <= cfg_data_i[CAL_W-1:0];
        REG_WHITE_RED:   white_q[0]  <= cfg_data_i[CAL_W-1:0];
        REG_WHITE_GREEN: white_q[1]  <= cfg_data_i[CAL_W-1:0];
        REG_WHITE_BLUE:  white_q[2]  <= cfg_data_i[CAL_W-1:0];
        REG_SCALE:       scale_q     <= cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  // Next measurement state for the offered item.
  always_comb begin
    edge_inc    = pin_level_i & ~prev_q & (count_q < COUNT_MAX);
    count_inc   = count_q + COUNT_W'(edge_inc);
    elapsed_inc = (elapsed_q != '1) ? elapsed_q + RT_W'(1) : elapsed_q;
    phase_d     = phase_q;
    count_d     = count_q;
    elapsed_d   = elapsed_q;
    prev_d      = prev_q;
    close       = 1'b0;
    if (op_i == OP_START) begin
      // A start while a sequence runs is ignored.
      if (phase_q == PH_IDLE) begin
        phase_d   = PH_RED;
        count_d   = '0;
        elapsed_d = '0;
        prev_d    = pin_level_i;
      end
    end else if (phase_q != PH_IDLE) begin
      prev_d  = pin_level_i;
      count_d = count_inc;
      if (ms_tick_i) begin
        elapsed_d = elapsed_inc;
        if (elapsed_inc >= rt_eff) begin
          close     = 1'b1;
          count_d   = '0;
          elapsed_d = '0;
          phase_d   = (phase_q == PH_BLUE) ? PH_IDLE : phase_e'(phase_q + 2'd1);
        end
      end
    end
  end

  // Measurement state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      count_q   <= '0;
      elapsed_q <= '0;
      prev_q    <= 1'b0;
    end else if (cmd_i.take) begin
      phase_q   <= phase_d;
      count_q   <= count_d;
      elapsed_q <= elapsed_d;
      prev_q    <= prev_d;
    end
  end

  // Frequency and calibration arithmetic around the shared divider.
  assign prod     = snap_q * MS_PER_S;
  assign freq_sat = (div_quot > DVD_W'(FREQ_MAX)) ? FREQ_MAX : div_quot[FREQ_W-1:0];
  assign abs_diff = diff_q[FREQ_W] ? -diff_q : diff_q;
  assign abs_den  = den_q[FREQ_W] ? -den_q : den_q;
  assign abs_num  = {abs_diff, 8'd0} - (FREQ_W+9)'(abs_diff);
  assign color    = !pos_q ? '0 :
                    (div_quot > DVD_W'(COLOR_MAX)) ? COLOR_MAX : div_quot[COLOR_W-1:0];

  always_comb begin
    div_start    = cmd_i.mul_start | cmd_i.cal_start;
    div_dividend = cmd_i.mul_start ? prod : DVD_W'(abs_num);
    div_divisor  = cmd_i.mul_start ? DSR_W'(rt_eff) : abs_den[DSR_W-1:0];
  end

  csfr_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .busy_o     (div_busy),
    .quotient_o (div_quot)
  );

  // Window snapshot and calibration operands.
  always_ff @(posedge clk_i) begin
    if (cmd_i.take && close) begin
      snap_q <= count_inc;
      ch_q   <= CH_W'(phase_q - 2'd1);
      last_q <= (phase_q == PH_BLUE);
    end
    if (cmd_i.cal_load) begin
      freq_q <= freq_sat;
      diff_q <= {1'b0, freq_sat} - {1'b0, dark_q[ch_q]};
      den_q  <= {1'b0, white_q[ch_q]} - {1'b0, dark_q[ch_q]};
    end
    if (cmd_i.cal_start) begin
      // Positive quotient only when both signs agree and the span is nonzero.
      pos_q <= (den_q != '0) && (diff_q[FREQ_W] == den_q[FREQ_W]);
    end
  end

  // Output register.
  assign out_free = ~out_valid_q | out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((cmd_i.take && !close) || cmd_i.finish) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take && !close) begin
      out_q.filter_pins   <= filter_code(phase_d);
      out_q.sensor_enable <= (phase_d != PH_IDLE);
      out_q.scale_pins    <= (phase_d != PH_IDLE) ? scale_q : 2'b00;
      out_q.busy_res      <= (phase_d != PH_IDLE);
      out_q.result_valid  <= 1'b0;
      out_q.channel       <= '0;
      out_q.raw_frequency <= '0;
      out_q.color_value   <= '0;
      out_q.last          <= 1'b0;
    end else if (cmd_i.finish) begin
      out_q.filter_pins   <= filter_code(phase_q);
      out_q.sensor_enable <= (phase_q != PH_IDLE);
      out_q.scale_pins    <= (phase_q != PH_IDLE) ? scale_q : 2'b00;
      out_q.busy_res      <= (phase_q != PH_IDLE);
      out_q.result_valid  <= 1'b1;
      out_q.channel       <= ch_q;
      out_q.raw_frequency <= freq_q;
      out_q.color_value   <= color;
      out_q.last          <= last_q;
    end
  end

  assign sts_o.close    = close;
  assign sts_o.out_free = out_free;
  assign sts_o.div_busy = div_busy;
  assign out_valid_o    = out_valid_q;
  assign out_item_o     = out_q;

endmodule

### design/csfr_ctrl.sv
module csfr_ctrl import csfr_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  csfr_sts_t sts_i,
  output csfr_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_DIV_F,
    S_CAL,
    S_START_C,
    S_DIV_C,
    S_FIN
  } state_e;

  state_e state_q, state_d;
  logic   take;

  assign in_ready_o = (state_q == S_IDLE) && sts_i.out_free;
  assign take       = in_valid_i && in_ready_o;

  // Next state and commands.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        cmd_o.take = take;
        if (take && sts_i.close) begin
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        cmd_o.mul_start = 1'b1;
        state_d         = S_DIV_F;
      end
      S_DIV_F: begin
        if (!sts_i.div_busy) begin
          state_d = S_CAL;
        end
      end
      S_CAL: begin
        cmd_o.cal_load = 1'b1;
        state_d        = S_START_C;
      end
      S_START_C: begin
        cmd_o.cal_start = 1'b1;
        state_d         = S_DIV_C;
      end
      S_DIV_C: begin
        if (!sts_i.div_busy) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (sts_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### design/color_sensor_frequency_reader_core.sv
// Channel    Dir  Handshake      Payload
// sample_i   in   valid/ready    op, pin_level, ms_tick
// result_o   out  valid/ready    filter_pins .. last (one item per input item)
// cfg_i      in   valid/ready    index, data
//
// An item that does not close a counting window is accepted while the reader
// is idle and the output register is empty or being drained.
// An item that closes a window holds the input off until its result is written:
// the shared 42-step serial divider runs once for the frequency and once for
// the color value, and the result then waits for a free output register.
// Reset loads the register defaults and leaves the reader idle.
// A stalled result holds the input off; configuration writes are always taken.
module color_sensor_frequency_reader_core import csfr_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  csfr_in_if.sink    sample_i,
  csfr_out_if.source result_o,
  csfr_cfg_if.sink   cfg_i
);

  csfr_cmd_t cmd;
  csfr_sts_t sts;
  result_t   item;
  logic      out_valid;

  assign cfg_i.ready = 1'b1;

  csfr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (sample_i.valid),
    .in_ready_o (sample_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  csfr_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .op_i        (sample_i.op),
    .pin_level_i (sample_i.pin_level),
    .ms_tick_i   (sample_i.ms_tick),
    .cfg_we_i    (cfg_i.valid),
    .cfg_index_i (cfg_i.index),
    .cfg_data_i  (cfg_i.data),
    .out_ready_i (result_o.ready),
    .out_valid_o (out_valid),
    .out_item_o  (item)
  );

  // Result item onto the output channel.
  assign result_o.valid         = out_valid;
  assign result_o.filter_pins   = item.filter_pins;
  assign result_o.sensor_enable = item.sensor_enable;
  assign result_o.scale_pins    = item.scale_pins;
  assign result_o.busy_res      = item.busy_res;
  assign result_o.result_valid  = item.result_valid;
  assign result_o.channel       = item.channel;
  assign result_o.raw_frequency = item.raw_frequency;
  assign result_o.color_value   = item.color_value;
  assign result_o.last          = item.last;

endmodule
